// File: src/csb_pkg.sv
// Shared types and constants for the cursor sequence buffer.
package csb_pkg;

  localparam int DEPTH      = 32;
  localparam int WORD_WIDTH = 32;
  localparam int CUR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int GROUP_SIZE = 8;
  localparam int GROUPS     = DEPTH / GROUP_SIZE;

  typedef enum logic [3:0] {
    ACT_START      = 4'd0,
    ACT_LAST       = 4'd1,
    ACT_END        = 4'd2,
    ACT_ADVANCE    = 4'd3,
    ACT_RETREAT    = 4'd4,
    ACT_INSERT     = 4'd5,
    ACT_ATTACH     = 4'd6,
    ACT_REMOVE     = 4'd7,
    ACT_FRONT      = 4'd8,
    ACT_BACK       = 4'd9,
    ACT_REMOVE_FRT = 4'd10,
    ACT_READ       = 4'd11
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] value;
    logic [4:0]  position;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  count;
    logic [4:0]  cursor;
    logic        has_current;
    logic [31:0] current_value;
    logic [31:0] position_value;
  } result_t;

  // shift command broadcast to every cell
  typedef struct packed {
    cell_op_e              op;
    logic [CUR_W-1:0]      at;
    logic [WORD_WIDTH-1:0] word;
  } cell_ctl_t;

  // read selection broadcast to every cell
  typedef struct packed {
    logic [CUR_W-1:0] cursor;
    logic             cursor_ok;
    logic [CUR_W-1:0] pos;
    logic             pos_ok;
  } cell_sel_t;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] count;
    logic [CUR_W-1:0] cursor;
  } ctrl_state_t;

endpackage

// File: src/csb_cell.sv
// One storage cell of the element chain.
module csb_cell (
  input  logic                          clk_i,
  input  logic [csb_pkg::CUR_W-1:0]     idx_i,
  input  csb_pkg::cell_ctl_t            ctl_i,
  input  csb_pkg::cell_sel_t            sel_i,
  input  logic [csb_pkg::WORD_WIDTH-1:0] left_i,
  input  logic [csb_pkg::WORD_WIDTH-1:0] right_i,
  output logic [csb_pkg::WORD_WIDTH-1:0] word_o,
  output logic [csb_pkg::WORD_WIDTH-1:0] cur_word_o,
  output logic [csb_pkg::WORD_WIDTH-1:0] pos_word_o
);
  import csb_pkg::*;

  logic [WORD_WIDTH-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (ctl_i.op)
      CELL_OPEN: begin
        if (idx_i == ctl_i.at) begin
          word_d = ctl_i.word;
        end else if (idx_i > ctl_i.at) begin
          word_d = left_i;
        end
      end
      CELL_CLOSE: begin
        if (idx_i >= ctl_i.at) begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o     = word_q;
  assign cur_word_o = (sel_i.cursor_ok && sel_i.cursor == idx_i) ? word_q : '0;
  assign pos_word_o = (sel_i.pos_ok && sel_i.pos == idx_i) ? word_q : '0;

endmodule

// File: src/csb_ctrl.sv
// Action decode, count and cursor registers, shift command for the cells.
module csb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  csb_pkg::item_t       item_i,
  output csb_pkg::cell_ctl_t   ctl_o,
  output csb_pkg::ctrl_state_t state_o
);
  import csb_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CUR_W-1:0] cursor_q, cursor_d;
  status_e          status_q, status_d;
  logic             has_cur, full;

  assign has_cur = {1'b0, cursor_q} < count_q;
  assign full    = count_q >= CNT_W'(DEPTH);

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    status_d = status_q;
    ctl_o    = '{op: CELL_HOLD, at: '0, word: item_i.value[WORD_WIDTH-1:0]};
    if (accept_i) begin
      status_d = ST_OK;
      case (action_e'(item_i.action))
        ACT_START: cursor_d = '0;
        ACT_LAST: begin
          if (count_q == '0) status_d = ST_EMPTY;
          else cursor_d = CUR_W'(count_q - CNT_W'(1));
        end
        ACT_END: cursor_d = CUR_W'(DEPTH - 1);
        ACT_ADVANCE: begin
          if (!has_cur) status_d = ST_EMPTY;
          else if (cursor_q != CUR_W'(DEPTH - 1)) cursor_d = cursor_q + CUR_W'(1);
        end
        ACT_RETREAT: begin
          if (cursor_q != '0) cursor_d = cursor_q - CUR_W'(1);
        end
        ACT_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctl_o.op = CELL_OPEN;
            count_d  = count_q + CNT_W'(1);
            if (has_cur) begin
              ctl_o.at = cursor_q;
            end else begin
              ctl_o.at = '0;
              cursor_d = '0;
            end
          end
        end
        ACT_ATTACH: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctl_o.op = CELL_OPEN;
            count_d  = count_q + CNT_W'(1);
            if (has_cur) begin
              ctl_o.at = cursor_q + CUR_W'(1);
              cursor_d = cursor_q + CUR_W'(1);
            end else begin
              ctl_o.at = CUR_W'(count_q);
              cursor_d = CUR_W'(count_q);
            end
          end
        end
        ACT_REMOVE: begin
          if (!has_cur) begin
            status_d = ST_EMPTY;
          end else begin
            ctl_o.op = CELL_CLOSE;
            ctl_o.at = cursor_q;
            count_d  = count_q - CNT_W'(1);
          end
        end
        ACT_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctl_o.op = CELL_OPEN;
            ctl_o.at = '0;
            cursor_d = '0;
            count_d  = count_q + CNT_W'(1);
          end
        end
        ACT_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctl_o.op = CELL_OPEN;
            ctl_o.at = CUR_W'(count_q);
            cursor_d = CUR_W'(count_q);
            count_d  = count_q + CNT_W'(1);
          end
        end
        ACT_REMOVE_FRT: begin
          if (!has_cur) begin
            status_d = ST_EMPTY;
          end else begin
            ctl_o.op = CELL_CLOSE;
            ctl_o.at = '0;
            cursor_d = '0;
            count_d  = count_q - CNT_W'(1);
          end
        end
        default: ;  // read and unused codes leave count and cursor alone and report OK
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      status_q <= ST_OK;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      status_q <= status_d;
    end
  end

  assign state_o = '{status: status_q, count: count_q, cursor: cursor_q};

endmodule

// File: src/cursor_sequence_buffer_top.sv
// Top level: cell chain, controller and registered read-out tree.
//
// An ordered list of up to 32 words with a count and a cursor. An item is taken when
// start is high and busy is low; its result is shown for one cycle, with result_valid_o
// high, and cannot be held off. The list update lands in the cell chain at the
// accepting edge (every cell shifts at once); then states S_RED1 and S_RED2 run the
// cursor and position words through a two-level registered OR tree over the cells.
// busy stays high in those states, so no new item is taken until the last one's
// result is registered, and the next item may start in the cycle its predecessor's
// result is shown.
module cursor_sequence_buffer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  csb_pkg::item_t    item_i,
  output csb_pkg::result_t  result_o,
  output logic              result_valid_o
);
  import csb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED1 = 2'd1;
  localparam logic [1:0] S_RED2 = 2'd2;

  logic [1:0]       state_q, state_d;
  logic             accept;
  cell_ctl_t        ctl;
  ctrl_state_t      cst;
  cell_sel_t        sel;
  logic [CUR_W-1:0] pos_q;

  logic [WORD_WIDTH-1:0] words    [DEPTH];
  logic [WORD_WIDTH-1:0] cur_w    [DEPTH];
  logic [WORD_WIDTH-1:0] pos_w    [DEPTH];
  logic [WORD_WIDTH-1:0] grp_cur_q[GROUPS];
  logic [WORD_WIDTH-1:0] grp_pos_q[GROUPS];
  logic [WORD_WIDTH-1:0] fin_cur, fin_pos;

  result_t res_q;
  logic    valid_q;

  assign accept = start && !busy;
  assign busy   = state_q != S_IDLE;

  csb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (item_i),
    .ctl_o   (ctl),
    .state_o (cst)
  );

  assign sel.cursor    = cst.cursor;
  assign sel.cursor_ok = {1'b0, cst.cursor} < cst.count;
  assign sel.pos       = pos_q;
  assign sel.pos_ok    = {1'b0, pos_q} < cst.count;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = words[g-1];
    end
    // last cell closes onto itself, which is a hold
    if (g == DEPTH - 1) begin : g_last
      assign right_w = words[g];
    end else begin : g_inner
      assign right_w = words[g+1];
    end
    csb_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (CUR_W'(g)),
      .ctl_i     (ctl),
      .sel_i     (sel),
      .left_i    (left_w),
      .right_i   (right_w),
      .word_o    (words[g]),
      .cur_word_o(cur_w[g]),
      .pos_word_o(pos_w[g])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_RED1;
      S_RED1:  state_d = S_RED2;
      S_RED2:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= state_q == S_RED2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) pos_q <= item_i.position;
  end

  // first tree level: one OR per group of cells
  always_ff @(posedge clk_i) begin
    if (state_q == S_RED1) begin
      for (int k = 0; k < GROUPS; k++) begin
        logic [WORD_WIDTH-1:0] ac, ap;
        ac = '0;
        ap = '0;
        for (int m = 0; m < GROUP_SIZE; m++) begin
          ac = ac | cur_w[k*GROUP_SIZE+m];
          ap = ap | pos_w[k*GROUP_SIZE+m];
        end
        grp_cur_q[k] <= ac;
        grp_pos_q[k] <= ap;
      end
    end
  end

  always_comb begin
    fin_cur = '0;
    fin_pos = '0;
    for (int k = 0; k < GROUPS; k++) begin
      fin_cur = fin_cur | grp_cur_q[k];
      fin_pos = fin_pos | grp_pos_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RED2) begin
      res_q.status         <= cst.status;
      res_q.count          <= 6'(cst.count);
      res_q.cursor         <= 5'(cst.cursor);
      res_q.has_current    <= sel.cursor_ok;
      res_q.current_value  <= 32'(fin_cur);
      res_q.position_value <= 32'(fin_pos);
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = valid_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_one_cycle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.count <= 6'(DEPTH))
    else $error("count above list depth");

  a_has_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (result_o.has_current == ({1'b0, result_o.cursor} < result_o.count)))
    else $error("has_current disagrees with cursor and count");

  a_no_current_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.has_current) |-> result_o.current_value == '0)
    else $error("current word not zero without a current item");

endmodule

// File: tb/cursor_sequence_buffer_top_tb.sv
// Testbench for the cursor sequence buffer: directed and random actions, checked against a predictor.
module cursor_sequence_buffer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csb_pkg::*;

  // codes beyond read behave as read
  localparam logic [3:0] ACT_SPARE_LO = 4'd12;
  localparam logic [3:0] ACT_SPARE_HI = 4'd15;
  localparam int RANDOM_ITEMS = 1390;
  localparam int MAX_PRINTS   = 60;

  typedef enum int { MODE_GROW, MODE_SHRINK, MODE_MIXED } mode_e;

  typedef struct {
    item_t item;
    int    gap;    // idle cycles before this item
    bit    drain;  // hold this item until every result is back
  } stim_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  result_t result_o;
  logic    result_valid_o;

  stim_t   action_queue[$];
  result_t predicted_results[$];
  int      gap_left = 0;
  int      mismatches = 0;

  // predictor state
  logic [WORD_WIDTH-1:0] list_words [DEPTH];
  int list_count = 0;
  int list_cursor = 0;

  cursor_sequence_buffer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void open_slot(int at, logic [WORD_WIDTH-1:0] word);
    for (int i = list_count; i > at; i--) list_words[i] = list_words[i-1];
    list_words[at] = word;
    list_count++;
  endfunction

  function automatic void close_slot(int at);
    for (int i = at; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
    list_count--;
  endfunction

  function automatic result_t apply_action(item_t it);
    result_t r;
    status_e st;
    bit      has_cur;
    bit      full;
    st      = ST_OK;
    has_cur = list_cursor < list_count;
    full    = list_count >= DEPTH;
    case (it.action)
      ACT_START: list_cursor = 0;
      ACT_LAST: begin
        if (list_count == 0) st = ST_EMPTY;
        else list_cursor = list_count - 1;
      end
      ACT_END: list_cursor = DEPTH - 1;
      ACT_ADVANCE: begin
        if (!has_cur) st = ST_EMPTY;
        else if (list_cursor != DEPTH - 1) list_cursor++;
      end
      ACT_RETREAT: begin
        if (list_cursor != 0) list_cursor--;
      end
      ACT_INSERT: begin
        if (full) st = ST_FULL;
        else if (!has_cur) begin
          open_slot(0, it.value);
          list_cursor = 0;
        end else begin
          open_slot(list_cursor, it.value);
        end
      end
      ACT_ATTACH: begin
        if (full) st = ST_FULL;
        else if (!has_cur) begin
          list_cursor = list_count;
          open_slot(list_count, it.value);
        end else begin
          list_cursor++;
          open_slot(list_cursor, it.value);
        end
      end
      ACT_REMOVE: begin
        if (!has_cur) st = ST_EMPTY;
        else close_slot(list_cursor);
      end
      ACT_FRONT: begin
        if (full) st = ST_FULL;
        else begin
          open_slot(0, it.value);
          list_cursor = 0;
        end
      end
      ACT_BACK: begin
        if (full) st = ST_FULL;
        else begin
          list_cursor = list_count;
          open_slot(list_count, it.value);
        end
      end
      ACT_REMOVE_FRT: begin
        if (!has_cur) st = ST_EMPTY;
        else begin
          list_cursor = 0;
          close_slot(0);
        end
      end
      default: ;
    endcase
    has_cur          = list_cursor < list_count;
    r.status         = st;
    r.count          = 6'(list_count);
    r.cursor         = 5'(list_cursor);
    r.has_current    = has_cur;
    r.current_value  = has_cur ? list_words[list_cursor] : '0;
    r.position_value = (int'(it.position) < list_count) ? list_words[it.position] : '0;
    return r;
  endfunction

  function automatic void add_item(logic [3:0] act, logic [31:0] word, logic [4:0] pos,
                                   int gap, bit drain);
    stim_t s;
    s.item.action   = act;
    s.item.value    = word;
    s.item.position = pos;
    s.gap           = gap;
    s.drain         = drain;
    action_queue.push_back(s);
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [3:0] pick_action(mode_e mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (r < 18) return ACT_INSERT;
        if (r < 36) return ACT_ATTACH;
        if (r < 52) return ACT_FRONT;
        if (r < 70) return ACT_BACK;
        if (r < 75) return ACT_END;
      end
      MODE_SHRINK: begin
        if (r < 40) return ACT_REMOVE;
        if (r < 58) return ACT_REMOVE_FRT;
        if (r < 70) return ACT_START;
        if (r < 78) return ACT_LAST;
      end
      default: ;
    endcase
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // driver: an item is taken when start is high and busy is low
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted_results.push_back(apply_action(item_i));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (action_queue.size() != 0 &&
                   !(action_queue[0].drain && predicted_results.size() != 0)) begin
        item_i <= action_queue[0].item;
        start  <= 1'b1;
        void'(action_queue.pop_front());
        if (action_queue.size() != 0) gap_left = action_queue[0].gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be held off, so every strobe is checked
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(result_o.count), '0);
      end else begin
        want = predicted_results.pop_front();
        if (result_o.status !== want.status)
          report_mismatch("status", 32'(result_o.status), 32'(want.status));
        if (result_o.count !== want.count)
          report_mismatch("count", 32'(result_o.count), 32'(want.count));
        if (result_o.cursor !== want.cursor)
          report_mismatch("cursor", 32'(result_o.cursor), 32'(want.cursor));
        if (result_o.has_current !== want.has_current)
          report_mismatch("has_current", 32'(result_o.has_current), 32'(want.has_current));
        if (result_o.current_value !== want.current_value)
          report_mismatch("current_value", result_o.current_value, want.current_value);
        if (result_o.position_value !== want.position_value)
          report_mismatch("position_value", result_o.position_value, want.position_value);
      end
    end
  end

  initial begin
    int    queued;
    int    phase_len;
    mode_e mode;
    bit    quiet;

    foreach (list_words[i]) list_words[i] = '0;

    // empty list: every action that needs an element must fail
    add_item(ACT_READ, 32'h0, 5'd0, 0, 0);
    add_item(ACT_LAST, 32'h1, 5'd31, 0, 0);
    add_item(ACT_ADVANCE, 32'h2, 5'd0, 1, 0);
    add_item(ACT_REMOVE, 32'h3, 5'd0, 0, 0);
    add_item(ACT_REMOVE_FRT, 32'h4, 5'd0, 0, 0);
    add_item(ACT_RETREAT, 32'h5, 5'd0, 2, 0);
    // insert without current acts as front
    add_item(ACT_INSERT, 32'hFFFF_FFFF, 5'd0, 0, 0);
    add_item(ACT_ATTACH, 32'h0, 5'd1, 0, 0);
    add_item(ACT_END, 32'h0, 5'd1, 0, 0);
    // attach without current acts as back
    add_item(ACT_ATTACH, 32'hA5A5_5A5A, 5'd2, 0, 0);
    add_item(ACT_END, 32'h0, 5'd2, 0, 0);
    add_item(ACT_INSERT, 32'h1234_5678, 5'd0, 0, 0);
    add_item(ACT_ADVANCE, 32'h0, 5'd3, 0, 0);
    add_item(ACT_INSERT, 32'h8000_0001, 5'd1, 0, 0);
    add_item(ACT_START, 32'h0, 5'd4, 3, 0);
    add_item(ACT_RETREAT, 32'h0, 5'd4, 0, 0);
    add_item(ACT_BACK, 32'h7FFF_FFFF, 5'd5, 0, 0);
    add_item(ACT_FRONT, 32'h0000_0001, 5'd5, 0, 0);
    add_item(ACT_REMOVE, 32'h0, 5'd2, 0, 0);
    // removing the last element leaves the cursor off the list
    add_item(ACT_LAST, 32'h0, 5'd3, 0, 0);
    add_item(ACT_REMOVE, 32'h0, 5'd3, 0, 0);
    add_item(ACT_REMOVE_FRT, 32'h0, 5'd0, 0, 0);
    add_item(ACT_SPARE_LO, 32'hFFFF_FFFF, 5'd0, 0, 0);
    add_item(ACT_SPARE_HI, 32'hFFFF_FFFF, 5'd31, 0, 0);
    // fill to full, then hit the full and top-cursor cases
    for (int i = 0; i < DEPTH + 2; i++) add_item(ACT_BACK, $urandom, 5'(i), 0, 0);
    add_item(ACT_END, 32'h0, 5'd31, 0, 0);
    add_item(ACT_ADVANCE, 32'h0, 5'd31, 0, 0);
    add_item(ACT_INSERT, 32'hDEAD_BEEF, 5'd31, 0, 0);
    add_item(ACT_READ, 32'h0, 5'd31, 0, 1);

    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      mode      = mode_e'($urandom_range(0, 2));
      quiet     = $urandom_range(0, 3) == 0;
      phase_len = $urandom_range(30, 90);
      for (int i = 0; i < phase_len && queued < RANDOM_ITEMS; i++) begin
        add_item(pick_action(mode), $urandom, 5'($urandom_range(0, 31)), pick_gap(quiet),
                 i == 0 && $urandom_range(0, 3) == 0);
        queued++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (action_queue.size() != 0 || start) @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[cursor_sequence_buffer_top] OK");
    end else begin
      $display("[cursor_sequence_buffer_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[cursor_sequence_buffer_top] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
src/csb_pkg.sv
src/csb_cell.sv
src/csb_ctrl.sv
src/cursor_sequence_buffer_top.sv
tb/cursor_sequence_buffer_top_tb.sv
